@@ sv/adq_pkg.sv @@
package adq_pkg;

   // Raw serial-audio words carry their data in the upper 24 bits.
   localparam int RAW_WIDTH    = 32;
   localparam int RAW_SHIFT    = 8;
   localparam int SAMPLE_WIDTH = RAW_WIDTH - RAW_SHIFT;

   localparam logic [7:0] PCM_MID = 8'd128;
   localparam logic [7:0] PCM_MAX = 8'd255;

   // Configuration register indexes.
   localparam logic [1:0] CSR_AC_SHIFT      = 2'd0;
   localparam logic [1:0] CSR_TRACK_SHIFT   = 2'd1;
   localparam logic [1:0] CSR_PACKET_LENGTH = 2'd2;

   // Configuration reset values.
   localparam logic [4:0] AC_SHIFT_RESET      = 5'd11;
   localparam logic [4:0] TRACK_SHIFT_RESET   = 5'd10;
   localparam logic [7:0] PACKET_LENGTH_RESET = 8'd200;

   typedef struct packed {
      logic [4:0] ac_shift;
      logic [4:0] track_shift;
      logic [7:0] packet_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  sample_index;
      logic [15:0] packet_seq;
      logic        last_in_packet;
   } tag_type;

endpackage

@@ sv/audio_decimate_dcblock_quantize.sv @@
// Audio decimator, DC blocker and 8-bit PCM packetizer.
//
// Input transactions (req_valid / req_stall) carry one 32-bit serial-audio
// word each. The block drops the low 8 bits, averages samples in pairs, removes
// the DC level with a one-pole tracker and quantizes the AC part to an
// unsigned byte centered at 128. Only the second sample of a pair produces a
// result transaction (rsp_valid / rsp_stall), tagged with its index in the
// packet, the packet sequence number and a last-in-packet flag.
// The configuration channel (csr_valid / csr_ready, csr_index, csr_data) is
// always ready; writes to an index past the register list are ignored.
// Registers should be written only while no transaction is in flight.
//
// An accepted sample sits in the input register, and the result of a completed
// pair is then loaded into the output register, which drives rsp_valid.
// Throughput is one sample per cycle while req_stall is low, set by the
// input and output registers each holding one transaction. When rsp_stall
// is high the output register holds its result; first-of-pair samples still
// drain, and the input stalls only when a paired sample needs the held slot.
// Synchronous reset clears the filter state and packet counters and returns
// the registers to their defaults.
module audio_decimate_dcblock_quantize
   import adq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_raw_sample,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pcm_byte,
   output logic [7:0]  rsp_sample_index,
   output logic [15:0] rsp_packet_seq,
   output logic        rsp_last_in_packet,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   cfg_type     cfg_ff, cfg_in;

   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_sample_ff, in_sample_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  pcm_ff;
   tag_type     tag_ff;

   logic        req_accept;
   logic        out_free;
   logic        pair_done;
   logic        consume;
   logic        produce;
   logic [7:0]  pcm_byte;
   tag_type     tag;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_AC_SHIFT:      cfg_in.ac_shift      = csr_data[4:0];
            CSR_TRACK_SHIFT:   cfg_in.track_shift   = csr_data[4:0];
            CSR_PACKET_LENGTH: cfg_in.packet_length = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Handshake. The output slot is free when empty or being taken this cycle.
   // A first-of-pair sample never needs the output slot.
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      consume    = in_valid_ff && (!pair_done || out_free);
      produce    = consume && pair_done;
      req_stall  = in_valid_ff && !consume;
      req_accept = req_valid && !req_stall;

      in_valid_in  = req_accept || (in_valid_ff && !consume);
      in_sample_in = req_accept ? req_raw_sample : in_sample_ff;
      rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);
   end

   adq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .enable     (consume),
      .raw_sample (in_sample_ff),
      .cfg        (cfg_ff),
      .pair_done  (pair_done),
      .pcm_byte   (pcm_byte)
   );

   adq_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .enable        (produce),
      .packet_length (cfg_ff.packet_length),
      .tag           (tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ac_shift      <= AC_SHIFT_RESET;
         cfg_ff.track_shift   <= TRACK_SHIFT_RESET;
         cfg_ff.packet_length <= PACKET_LENGTH_RESET;
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_sample_ff <= in_sample_in;
      if (produce) begin
         pcm_ff <= pcm_byte;
         tag_ff <= tag;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pcm_byte       = pcm_ff;
   assign rsp_sample_index   = tag_ff.sample_index;
   assign rsp_packet_seq     = tag_ff.packet_seq;
   assign rsp_last_in_packet = tag_ff.last_in_packet;

   // A completed pair always lands in the output register.
   a_produce: assert property (@(posedge clock) disable iff (reset)
      produce |=> rsp_valid_ff)
      else $error("completed pair did not reach the output register");

   // A produced result never overwrites one that is still being held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      produce |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

endmodule

@@ sv/adq_datapath.sv @@
module adq_datapath
   import adq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic signed [31:0]    raw_sample,
   input  cfg_type               cfg,
   output logic                  pair_done,
   output logic [7:0]            pcm_byte
);

   logic signed [SAMPLE_WIDTH-1:0] held_sample_ff, held_sample_in;
   logic                           have_first_ff, have_first_in;
   logic signed [SAMPLE_WIDTH-1:0] dc_level_ff, dc_level_in;

   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic signed [SAMPLE_WIDTH:0]   pair_sum;
   logic signed [SAMPLE_WIDTH-1:0] average;
   logic signed [SAMPLE_WIDTH:0]   dc_error;
   logic signed [SAMPLE_WIDTH:0]   dc_step;
   logic signed [SAMPLE_WIDTH:0]   dc_next;
   logic signed [SAMPLE_WIDTH:0]   ac_part;
   logic signed [SAMPLE_WIDTH:0]   ac_scaled;
   logic signed [SAMPLE_WIDTH+1:0] offset_value;

   // The second sample of a pair completes an output.
   assign pair_done = have_first_ff;

   always_comb begin
      sample       = raw_sample[RAW_WIDTH-1:RAW_SHIFT];
      pair_sum     = {held_sample_ff[SAMPLE_WIDTH-1], held_sample_ff}
                     + {sample[SAMPLE_WIDTH-1], sample};
      average      = pair_sum[SAMPLE_WIDTH:1];
      dc_error     = {average[SAMPLE_WIDTH-1], average}
                     - {dc_level_ff[SAMPLE_WIDTH-1], dc_level_ff};
      dc_step      = dc_error >>> cfg.track_shift;
      dc_next      = {dc_level_ff[SAMPLE_WIDTH-1], dc_level_ff} + dc_step;
      ac_part      = {average[SAMPLE_WIDTH-1], average} - dc_next;
      ac_scaled    = ac_part >>> cfg.ac_shift;
      offset_value = {ac_scaled[SAMPLE_WIDTH], ac_scaled}
                     + $signed({{(SAMPLE_WIDTH-6){1'b0}}, PCM_MID});
      if (offset_value[SAMPLE_WIDTH+1]) begin
         pcm_byte = 8'd0;
      end else if (offset_value > $signed({{(SAMPLE_WIDTH-6){1'b0}}, PCM_MAX})) begin
         pcm_byte = PCM_MAX;
      end else begin
         pcm_byte = offset_value[7:0];
      end
   end

   always_comb begin
      held_sample_in = held_sample_ff;
      have_first_in  = have_first_ff;
      dc_level_in    = dc_level_ff;
      if (enable) begin
         have_first_in = !have_first_ff;
         if (have_first_ff) begin
            dc_level_in = dc_next[SAMPLE_WIDTH-1:0];
         end else begin
            held_sample_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_sample_ff <= '0;
         have_first_ff  <= 1'b0;
         dc_level_ff    <= '0;
      end else begin
         held_sample_ff <= held_sample_in;
         have_first_ff  <= have_first_in;
         dc_level_ff    <= dc_level_in;
      end
   end

   // The DC level moves only when a pair completes.
   a_dc_hold: assert property (@(posedge clock) disable iff (reset)
      !(enable && have_first_ff) |=> $stable(dc_level_ff))
      else $error("DC level changed without a completed pair");

   // Every consumed sample flips the pairing phase.
   a_phase_flip: assert property (@(posedge clock) disable iff (reset)
      enable |=> (have_first_ff != $past(have_first_ff)))
      else $error("pairing phase did not advance");

endmodule

@@ sv/adq_framer.sv @@
module adq_framer
   import adq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  logic [7:0] packet_length,
   output tag_type    tag
);

   logic [7:0]  fill_count_ff, fill_count_in;
   logic [15:0] seq_number_ff, seq_number_in;
   logic [7:0]  fill_next;
   logic        closes;

   always_comb begin
      fill_next          = fill_count_ff + 8'd1;
      // A zero packet length acts as a length of one.
      closes             = (fill_next >= packet_length) || (fill_next == 8'd0);
      tag.sample_index   = fill_count_ff;
      tag.packet_seq     = seq_number_ff;
      tag.last_in_packet = closes;
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      seq_number_in = seq_number_ff;
      if (enable) begin
         if (closes) begin
            fill_count_in = 8'd0;
            seq_number_in = seq_number_ff + 16'd1;
         end else begin
            fill_count_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         seq_number_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
         seq_number_ff <= seq_number_in;
      end
   end

   // Closing a packet restarts the index and advances the sequence number.
   a_close: assert property (@(posedge clock) disable iff (reset)
      (enable && closes) |=> (fill_count_ff == 8'd0)
                             && (seq_number_ff == $past(seq_number_ff) + 16'd1))
      else $error("packet close did not restart the index");

   // The fill count can never reach the top code.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff != 8'd255)
      else $error("fill count out of range");

endmodule

@@ tb/tb_audio_decimate_dcblock_quantize.sv @@
`timescale 1ns / 100ps

module tb_audio_decimate_dcblock_quantize;
   import adq_pkg::*;

   // Index just past the register list. The block must ignore writes to it.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Cycles that let a first-of-pair sample clear the block with no result.
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      logic [7:0]  pcm_byte;
      logic [7:0]  sample_index;
      logic [15:0] packet_seq;
      logic        last_in_packet;
   } pcm_tagged_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_raw_sample = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pcm_byte;
   logic [7:0]  rsp_sample_index;
   logic [15:0] rsp_packet_seq;
   logic        rsp_last_in_packet;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // Raw words waiting to be offered, and the tagged bytes that the accepted
   // words must produce, oldest first.
   logic [31:0]    sample_queue[$];
   pcm_tagged_type pcm_expected[$];

   // When idle_on is low, neither side inserts gaps or stalls.
   bit          idle_on = 1'b1;
   bit          failed = 1'b0;
   int          gap_cnt = 0;
   int          stall_cnt = 0;

   // Our own copy of the block's registers and filter state.
   logic [4:0]         q_shift;
   logic [4:0]         trk_shift;
   logic [7:0]         pkt_len;
   logic signed [23:0] pair_first;
   logic               pair_open;
   logic signed [23:0] dc_track;
   logic [7:0]         byte_pos;
   logic [15:0]        packet_num;

   audio_decimate_dcblock_quantize uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_sample     (req_raw_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pcm_byte       (rsp_pcm_byte),
      .rsp_sample_index   (rsp_sample_index),
      .rsp_packet_seq     (rsp_packet_seq),
      .rsp_last_in_packet (rsp_last_in_packet),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #1 clock = ~clock;

   // Gap length for either side. Most gaps are zero or short, a few are long,
   // and in phases without idling there are none at all.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random serial-audio word. Most words are a DC level plus noise scaled to
   // the quantizer shift, so the bytes spread over the whole PCM range instead
   // of sitting at the clamps. The low 8 bits are random and must be dropped.
   function automatic logic [31:0] make_sample(input int qs, input int offset);
      int amp;
      int level;
      amp = 1 << ((qs > 14) ? 22 : qs + 8);
      level = offset + int'($urandom_range(0, 2 * amp)) - amp;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return {level[23:0], 8'($urandom)};
      endcase
   endfunction

   // Computes the tagged byte that one accepted word produces, if any. The
   // first word of a pair is only held. The second is averaged with it, the
   // average pulls the DC tracker toward itself, and what is left over is
   // quantized around 128 and clamped to a byte.
   task automatic predict_pcm(input logic [31:0] raw);
      longint         s;
      longint         avg;
      longint         dc_now;
      longint         ac;
      longint         q;
      pcm_tagged_type r;
      s = longint'($signed(raw)) >>> RAW_SHIFT;
      if (!pair_open) begin
         pair_first = s[23:0];
         pair_open = 1'b1;
         return;
      end
      pair_open = 1'b0;
      avg = (longint'(pair_first) + s) >>> 1;
      dc_now = longint'(dc_track) + ((avg - longint'(dc_track)) >>> trk_shift);
      dc_track = dc_now[23:0];
      ac = avg - dc_now;
      // The offset is cast to a signed type so that the shift stays arithmetic.
      q = (ac >>> q_shift) + longint'(PCM_MID);
      if (q < 0)
         q = 0;
      else if (q > longint'(PCM_MAX))
         q = longint'(PCM_MAX);
      r.pcm_byte = q[7:0];
      r.sample_index = byte_pos;
      r.packet_seq = packet_num;
      // A packet closes when the count reaches the length. A length of zero,
      // or a length lowered below the count, closes it at the next byte.
      byte_pos = byte_pos + 8'd1;
      if (byte_pos >= pkt_len || byte_pos == 8'd0) begin
         r.last_in_packet = 1'b1;
         byte_pos = 8'd0;
         packet_num = packet_num + 16'd1;
      end else begin
         r.last_in_packet = 1'b0;
      end
      pcm_expected.push_back(r);
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failed = 1'b1;
      end
   endtask

   // Driver. A new word is offered only when the current one has been taken
   // or none is offered, so a stalled payload is held unchanged. After each
   // word the driver may idle for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_cnt <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_cnt != 0) begin
            req_valid <= 1'b0;
            gap_cnt <= gap_cnt - 1;
         end else if (sample_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_raw_sample <= sample_queue.pop_front();
            gap_cnt <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor. All handshakes are sampled here at the clock edge, with the
   // values the block itself sees: a result transaction is checked before
   // the input transaction of the same edge updates the prediction, and
   // register writes update our copy of the configuration. This block also
   // stalls the result side in random bursts.
   always @(posedge clock) begin
      pcm_tagged_type want;
      if (reset) begin
         q_shift = AC_SHIFT_RESET;
         trk_shift = TRACK_SHIFT_RESET;
         pkt_len = PACKET_LENGTH_RESET;
         pair_first = '0;
         pair_open = 1'b0;
         dc_track = '0;
         byte_pos = '0;
         packet_num = '0;
         pcm_expected.delete();
         rsp_stall <= 1'b0;
         stall_cnt <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pcm_expected.size() == 0) begin
               $display("%0t: result transaction with nothing expected, actual pcm_byte %0d",
                        $time, rsp_pcm_byte);
               failed = 1'b1;
            end else begin
               want = pcm_expected.pop_front();
               check_field("pcm_byte", want.pcm_byte, rsp_pcm_byte);
               check_field("sample_index", want.sample_index, rsp_sample_index);
               check_field("packet_seq", want.packet_seq, rsp_packet_seq);
               check_field("last_in_packet", want.last_in_packet, rsp_last_in_packet);
            end
         end
         if (req_valid && !req_stall)
            predict_pcm(req_raw_sample);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AC_SHIFT:      q_shift = csr_data[4:0];
               CSR_TRACK_SHIFT:   trk_shift = csr_data[4:0];
               CSR_PACKET_LENGTH: pkt_len = csr_data;
               default: ;
            endcase
         end
         if (stall_cnt != 0) begin
            rsp_stall <= 1'b1;
            stall_cnt <= stall_cnt - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_cnt <= pick_gap();
         end
      end
   end

   // One register write. The write takes place at the edge where valid and
   // ready are both high, and valid is lowered at that same edge.
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every queued word has been accepted and every expected byte
   // has arrived, then lets a trailing first-of-pair word clear the block.
   task automatic drain();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || pcm_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One random phase: new register values (with random bits above the shift
   // fields, which the block must drop), a random DC level, then n words.
   task automatic random_phase(input int n, input int qs, input int ds, input int len,
                               input bit idle);
      int offset;
      write_reg(CSR_AC_SHIFT, {3'($urandom), 5'(qs)});
      write_reg(CSR_TRACK_SHIFT, {3'($urandom), 5'(ds)});
      write_reg(CSR_PACKET_LENGTH, 8'(len));
      idle_on = idle;
      offset = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      repeat (n) sample_queue.push_back(make_sample(qs, offset));
      drain();
   endtask

   initial begin
      int qs;
      int ds;
      int len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings. Full-scale words in both directions drive the byte
      // into both clamps; the low 8 bits alone must have no effect.
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h0000_00FF);
      sample_queue.push_back(32'hFFFF_FF00);
      drain();

      // A DC shift of zero makes the tracker follow the average, so every
      // byte is silence. A packet length of zero acts as a length of one.
      write_reg(CSR_AC_SHIFT, 8'd0);
      write_reg(CSR_TRACK_SHIFT, 8'd0);
      write_reg(CSR_PACKET_LENGTH, 8'd0);
      sample_queue.push_back(32'h0123_4500);
      sample_queue.push_back(32'hFEDC_BA00);
      sample_queue.push_back(32'h7FFF_FF00);
      sample_queue.push_back(32'h8000_00FF);
      drain();

      // Shift fields out of their usual range, written with all upper bits
      // set, and a write to the unused index that must change nothing.
      write_reg(CSR_AC_SHIFT, 8'hFF);
      write_reg(CSR_TRACK_SHIFT, 8'hE1);
      write_reg(CSR_PACKET_LENGTH, 8'd1);
      write_reg(CSR_UNUSED, 8'h55);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h5A5A_A5A5);
      drain();

      // Open a packet of ten, stop at five bytes, then lower the length to
      // two: the next byte must close the packet.
      write_reg(CSR_AC_SHIFT, 8'd4);
      write_reg(CSR_TRACK_SHIFT, 8'd2);
      write_reg(CSR_PACKET_LENGTH, 8'd10);
      repeat (10) sample_queue.push_back(make_sample(4, 0));
      drain();
      write_reg(CSR_PACKET_LENGTH, 8'd2);
      repeat (2) sample_queue.push_back(make_sample(4, 0));
      drain();

      // Longest packet, long enough to reach the top sample index.
      random_phase(515, 11, 10, 255, 1'b1);

      // Shorter phases with odd word counts, so a half pair crosses each
      // register change. The first three hold the range extremes; one phase
      // runs with no idling on either side.
      for (int p = 0; p < 6; p++) begin
         qs = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 31) : $urandom_range(0, 24);
         ds = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 12);
         case (p)
            0: begin qs = 0;  ds = 16; len = 3; end
            1: begin qs = 24; ds = 1;  len = 1; end
            2: begin qs = 31; ds = 0;  len = 0; end
            default: ;
         endcase
         random_phase(2 * $urandom_range(8, 14) + 1, qs, ds, len, p != 3);
      end

      // One byte per packet over a longer stretch with no idling, so the
      // sequence number advances on every byte.
      random_phase(121, $urandom_range(0, 24), $urandom_range(1, 16), 1, 1'b0);

      if (!failed && pcm_expected.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule
